// ----- rtl/qsr_pkg.sv -----
`default_nettype none
package qsr_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 28;
  localparam int SQ_W       = 130;
  localparam int SQ_LIM     = 128;
  localparam int ROOT_W     = 65;
  localparam int K_W        = 7;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int dnw(input int w);
    return max2(2 * w + 1, ROOT_W);
  endfunction

  function automatic int dvw(input int w, input int f);
    return w + f + 64;
  endfunction

  function automatic int qbw(input int w, input int f);
    return max2(w + 1, f + 2);
  endfunction

  function automatic int rw(input int w, input int f);
    return max2(qbw(w, f), ROOT_W) + 1;
  endfunction

  function automatic logic [1:0] term_b(input logic [1:0] c, input logic [1:0] t);
    return c ^ t;
  endfunction

  function automatic logic term_n(input logic [1:0] c, input logic [1:0] t);
    logic r;
    r = 1'b0;
    case (c)
      2'd0: r = (t != 2'd0);
      2'd1: r = (t == 2'd3);
      2'd2: r = (t == 2'd1);
      2'd3: r = (t == 2'd2);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/qsr_mul.sv -----
`default_nettype none
module qsr_mul #(
  parameter int W = qsr_pkg::COMP_WIDTH
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic      [2*W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ----- rtl/qsr_divsqrt.sv -----
`default_nettype none
module qsr_divsqrt #(
  parameter int W = qsr_pkg::COMP_WIDTH,
  parameter int F = qsr_pkg::FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic                        sqrt_mode,
  input  wire logic [qsr_pkg::dvw(W,F)-1:0] num,
  input  wire logic [qsr_pkg::dnw(W)-1:0]  den,
  input  wire logic [qsr_pkg::SQ_W-1:0]    op,
  output logic                             done,
  output logic                             ovf,
  output logic      [qsr_pkg::rw(W,F)-1:0] res
);
  localparam int DNW  = qsr_pkg::dnw(W);
  localparam int DVW  = qsr_pkg::dvw(W, F);
  localparam int QB   = qsr_pkg::qbw(W, F);
  localparam int RW   = qsr_pkg::rw(W, F);
  localparam int RMW  = qsr_pkg::max2(DNW + 1, qsr_pkg::ROOT_W + 4);
  localparam int SUBW = RMW + 1;
  localparam int CW   = $clog2(qsr_pkg::max2(QB, qsr_pkg::ROOT_W) + 1);

  typedef enum logic [1:0] {U_IDLE, U_RUN, U_RND} ustate_t;

  ustate_t          state;
  logic             mode;
  logic [RMW-1:0]   rem;
  logic [QB-1:0]    lo_div;
  logic [qsr_pkg::SQ_W-1:0] lo_sq;
  logic [DNW-1:0]   dreg;
  logic [CW-1:0]    cnt;
  logic [SUBW-1:0]  sa, sb, diff;
  logic             ge;
  logic [DVW-QB-1:0] hi;

  assign hi = num[DVW-1:QB];

  always_comb begin
    if (state == U_RND) begin
      sa = SUBW'(rem) << 1;
      sb = SUBW'(dreg);
    end else if (mode) begin
      sa = (SUBW'(rem) << 2) | SUBW'(lo_sq[qsr_pkg::SQ_W-1 -: 2]);
      sb = (SUBW'(res) << 2) | SUBW'(1);
    end else begin
      sa = (SUBW'(rem) << 1) | SUBW'(lo_div[QB-1]);
      sb = SUBW'(dreg);
    end
    diff = sa - sb;
    ge   = !diff[SUBW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      ovf   <= 1'b0;
      mode  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (go) begin
            mode <= sqrt_mode;
            res  <= '0;
            ovf  <= 1'b0;
            dreg <= den;
            if (sqrt_mode) begin
              rem   <= '0;
              lo_sq <= op;
              cnt   <= CW'(qsr_pkg::ROOT_W);
              state <= U_RUN;
            end else if ((DVW + DNW)'(hi) >= (DVW + DNW)'(den)) begin
              ovf  <= 1'b1;
              done <= 1'b1;
            end else begin
              rem    <= RMW'(hi);
              lo_div <= num[QB-1:0];
              cnt    <= CW'(QB);
              state  <= U_RUN;
            end
          end
        end
        U_RUN: begin
          rem    <= ge ? diff[RMW-1:0] : sa[RMW-1:0];
          res    <= (res << 1) | RW'(ge);
          lo_div <= lo_div << 1;
          lo_sq  <= lo_sq << 2;
          cnt    <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            if (mode) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              state <= U_RND;
            end
          end
        end
        U_RND: begin
          res   <= res + RW'(ge);
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/quaternion_series_reorient.sv -----
// With normalization off and no new reference, a word needs only the product; the shared
//   multiplier forms the products in turn (4 for the norm, 16 for the product).
// Normalization adds the norm, a leading-zero shift, a square root and four divides of QB
//   quotient bits, QB = max(COMP_WIDTH + 1, FRAC_BITS + 2); a new reference adds the norm and four divides.
// Flow: one word at a time; the next word is taken while a result waits.
// Reset: synchronous; clears control, normalize_enable to 1, stored inverse to zero.
`default_nettype none
module quaternion_series_reorient #(
  parameter int COMP_WIDTH = qsr_pkg::COMP_WIDTH,
  parameter int FRAC_BITS  = qsr_pkg::FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COMP_WIDTH-1:0] in_w,
  input  wire logic [COMP_WIDTH-1:0] in_x,
  input  wire logic [COMP_WIDTH-1:0] in_y,
  input  wire logic [COMP_WIDTH-1:0] in_z,
  input  wire logic                  series_start,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [COMP_WIDTH-1:0] out_w,
  output logic      [COMP_WIDTH-1:0] out_x,
  output logic      [COMP_WIDTH-1:0] out_y,
  output logic      [COMP_WIDTH-1:0] out_z,
  output logic                       saturated
);
  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W + 1;
  localparam int DNW = qsr_pkg::dnw(W);
  localparam int DVW = qsr_pkg::dvw(W, F);
  localparam int RW  = qsr_pkg::rw(W, F);
  localparam int SQW = qsr_pkg::SQ_W;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_N2, S_N2CHK, S_LZ, S_SQ_GO, S_SQ_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_DIV_FIN, S_PMUL, S_PFIN, S_DONE
  } state_t;

  state_t state;
  logic   norm_en, start_r, stage_inv, ph, pneg;
  logic [1:0] ci, ti;
  logic [W-1:0] qm [4];
  logic         qn [4];
  logic [W-1:0] im [4];
  logic         ineg [4];
  logic [W-1:0] ores [4];
  logic         sat_r;
  logic [PW-1:0] n2, pos, neg;
  logic [SQW-1:0] sq;
  logic [qsr_pkg::K_W-1:0] kk;
  logic [qsr_pkg::ROOT_W-1:0] root;

  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] mp;
  logic [1:0]     tb;

  logic           ds_go, ds_sqrt, ds_done, ds_ovf;
  logic [DVW-1:0] ds_num;
  logic [DNW-1:0] ds_den;
  logic [RW-1:0]  ds_res;

  logic [W-1:0] din [4];
  assign din[0] = in_w;
  assign din[1] = in_x;
  assign din[2] = in_y;
  assign din[3] = in_z;

  assign tb = qsr_pkg::term_b(ci, ti);

  always_comb begin
    if (state == S_N2) begin
      ma = qm[ci];
      mb = qm[ci];
    end else begin
      ma = im[ti];
      mb = qm[tb];
    end
  end

  qsr_mul #(.W(W)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign ds_go   = (state == S_SQ_GO) || (state == S_DIV_GO);
  assign ds_sqrt = (state == S_SQ_GO);
  assign ds_num  = stage_inv ? (DVW'(qm[ci]) << (2 * F)) : (DVW'(qm[ci]) << (F + kk));
  assign ds_den  = stage_inv ? DNW'(n2) : DNW'(root);

  qsr_divsqrt #(.W(W), .F(F)) u_ds (
    .clk(clk), .rst(rst), .go(ds_go), .sqrt_mode(ds_sqrt), .num(ds_num), .den(ds_den),
    .op(sq), .done(ds_done), .ovf(ds_ovf), .res(ds_res)
  );

  // divide result clip
  logic          dsgn, dsat;
  logic [W-1:0]  dlim, dmag;
  always_comb begin
    dsgn = stage_inv ? (qn[ci] ^ (ci != 2'd0)) : qn[ci];
    dlim = dsgn ? HALF : MAXP;
    dsat = ds_ovf || (ds_res > RW'(dlim));
    dmag = dsat ? dlim : ds_res[W-1:0];
  end

  // product component rounding and clip
  logic          pdn, psat;
  logic [PW-1:0] pdiff;
  logic [PW:0]   prnd, plim;
  logic [W-1:0]  pmag;
  always_comb begin
    pdn   = neg > pos;
    pdiff = pdn ? (neg - pos) : (pos - neg);
    prnd  = ((PW+1)'(pdiff) + ((PW+1)'(1) << (F - 1))) >> F;
    plim  = (PW+1)'(pdn ? HALF : MAXP);
    psat  = prnd > plim;
    pmag  = psat ? plim[W-1:0] : prnd[W-1:0];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      norm_en   <= 1'b1;
      out_valid <= 1'b0;
      start_r   <= 1'b0;
      stage_inv <= 1'b0;
      ph        <= 1'b0;
      ci        <= '0;
      ti        <= '0;
      for (int i = 0; i < 4; i++) begin
        im[i]   <= '0;
        ineg[i] <= 1'b0;
      end
    end else begin
      if (cfg_write) norm_en <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 4; i++) begin
              qn[i] <= din[i][W-1];
              qm[i] <= din[i][W-1] ? (~din[i] + W'(1)) : din[i];
            end
            start_r <= series_start;
            ci      <= '0;
            ti      <= '0;
            ph      <= 1'b0;
            n2      <= '0;
            pos     <= '0;
            neg     <= '0;
            sat_r   <= 1'b0;
            if (norm_en) begin
              stage_inv <= 1'b0;
              state     <= S_N2;
            end else if (series_start) begin
              stage_inv <= 1'b1;
              state     <= S_N2;
            end else begin
              state <= S_PMUL;
            end
          end
        end
        S_N2: begin
          ph <= ~ph;
          if (ph) begin
            n2 <= n2 + PW'(mp);
            ci <= ci + 2'd1;
            if (ci == 2'd3) state <= S_N2CHK;
          end
        end
        S_N2CHK: begin
          ci <= '0;
          if (n2 == '0) begin
            if (stage_inv) begin
              for (int i = 0; i < 4; i++) begin
                im[i]   <= '0;
                ineg[i] <= 1'b0;
              end
              state <= S_PMUL;
            end else if (start_r) begin
              stage_inv <= 1'b1;
              state     <= S_N2;
            end else begin
              state <= S_PMUL;
            end
          end else if (stage_inv) begin
            state <= S_DIV_GO;
          end else begin
            sq    <= SQW'(n2);
            kk    <= '0;
            state <= S_LZ;
          end
        end
        S_LZ: begin
          if (sq[SQW-1:qsr_pkg::SQ_LIM-2] == '0) begin
            sq <= sq << 2;
            kk <= kk + qsr_pkg::K_W'(1);
          end else begin
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (ds_done) begin
            root  <= ds_res[qsr_pkg::ROOT_W-1:0];
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: if (ds_done) state <= S_DIV_FIN;
        S_DIV_FIN: begin
          if (stage_inv) begin
            im[ci]   <= dmag;
            ineg[ci] <= dsgn && (dmag != '0);
          end else begin
            qm[ci] <= dmag;
            qn[ci] <= dsgn && (dmag != '0);
          end
          ci <= ci + 2'd1;
          if (ci == 2'd3) begin
            if (!stage_inv && start_r) begin
              stage_inv <= 1'b1;
              n2        <= '0;
              ph        <= 1'b0;
              state     <= S_N2;
            end else begin
              state <= S_PMUL;
            end
          end else begin
            state <= S_DIV_GO;
          end
        end
        S_PMUL: begin
          ph <= ~ph;
          if (!ph) begin
            pneg <= (ineg[ti] ^ qn[tb]) ^ qsr_pkg::term_n(ci, ti);
          end else begin
            if (pneg) neg <= neg + PW'(mp);
            else      pos <= pos + PW'(mp);
            ti <= ti + 2'd1;
            if (ti == 2'd3) state <= S_PFIN;
          end
        end
        S_PFIN: begin
          ores[ci] <= (pdn && pmag != '0) ? (~pmag + W'(1)) : pmag;
          sat_r    <= sat_r | psat;
          pos      <= '0;
          neg      <= '0;
          ci       <= ci + 2'd1;
          state    <= (ci == 2'd3) ? S_DONE : S_PMUL;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_w     <= ores[0];
            out_x     <= ores[1];
            out_y     <= ores[2];
            out_z     <= ores[3];
            saturated <= sat_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/qsr_checker.sv -----
`default_nettype none
module qsr_checker #(
  parameter int W = qsr_pkg::COMP_WIDTH
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [W-1:0] out_w,
  input wire logic [W-1:0] out_x,
  input wire logic [W-1:0] out_y,
  input wire logic [W-1:0] out_z,
  input wire logic         saturated
);
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("word out of reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(saturated))
    else $error("stalled word changed");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> out_w == HALF || out_w == MAXP || out_x == HALF ||
      out_x == MAXP || out_y == HALF || out_y == MAXP || out_z == HALF || out_z == MAXP)
    else $error("saturated without clipped part");
endmodule

bind quaternion_series_reorient qsr_checker #(.W(COMP_WIDTH)) u_qsr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_w(out_w), .out_x(out_x),
  .out_y(out_y), .out_z(out_z), .saturated(saturated)
);
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  typedef logic [255:0] big_t;
  typedef logic [qsr_pkg::COMP_WIDTH-1:0] comp_word_t;

  typedef struct {
    comp_word_t w, x, y, z;
    logic       sat;
  } rotated_word_t;

  // sign flip of each Hamilton term, one row per output component, bit t per term
  localparam logic [3:0] TERM_FLIP [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  class reorient_scoreboard;
    bit            norm_en;
    bit            inv_neg [4];
    logic [63:0]   inv_mag [4];
    bit            qn [4];
    logic [63:0]   qm [4];
    rotated_word_t expected [$];

    function new();
      norm_en = 1'b1;
      for (int i = 0; i < 4; i++) begin
        inv_neg[i] = 1'b0;
        inv_mag[i] = '0;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function int bitlen(big_t v);
      for (int i = 255; i >= 0; i--)
        if (v[i]) return i + 1;
      return 0;
    endfunction

    function big_t isqrt(big_t n);
      big_t r, t;
      r = '0;
      for (int b = 127; b >= 0; b--) begin
        t = r | (big_t'(1) << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function big_t div_round(big_t num, big_t den);
      big_t q, rm;
      q = num / den;
      rm = num % den;
      if ((rm << 1) >= den) q = q + 1;
      return q;
    endfunction

    function void clip(input bit neg, input big_t m, inout bit flag,
                       output bit on, output logic [63:0] om);
      big_t lim;
      lim = neg ? (big_t'(1) << (qsr_pkg::COMP_WIDTH - 1))
                : ((big_t'(1) << (qsr_pkg::COMP_WIDTH - 1)) - 1);
      if (m > lim) begin
        m = lim;
        flag = 1'b1;
      end
      om = m[63:0];
      on = neg && (om != 0);
    endfunction

    function big_t sample_norm_sq();
      big_t s;
      s = '0;
      for (int i = 0; i < 4; i++) s = s + big_t'(qm[i]) * big_t'(qm[i]);
      return s;
    endfunction

    function void unit_scale();
      big_t n2, r;
      int len, k;
      bit junk;
      n2 = sample_norm_sq();
      if (n2 == 0) return;
      len = bitlen(n2);
      k = (len < 128) ? (128 - len) / 2 : 0;
      r = isqrt(n2 << (2 * k));
      for (int i = 0; i < 4; i++)
        clip(qn[i], div_round(big_t'(qm[i]) << (qsr_pkg::FRAC_BITS + k), r), junk,
             qn[i], qm[i]);
    endfunction

    function void take_reference();
      big_t n2;
      bit junk;
      n2 = sample_norm_sq();
      for (int i = 0; i < 4; i++) begin
        if (n2 == 0) begin
          inv_neg[i] = 1'b0;
          inv_mag[i] = '0;
        end else begin
          clip(qn[i] ^ (i > 0),
               div_round(big_t'(qm[i]) << (2 * qsr_pkg::FRAC_BITS), n2), junk,
               inv_neg[i], inv_mag[i]);
        end
      end
    endfunction

    function void note_input(comp_word_t w, comp_word_t x, comp_word_t y, comp_word_t z,
                             logic start);
      comp_word_t raw [4];
      big_t pos, neg, p, m;
      bit flag, sn, on;
      logic [63:0] om;
      comp_word_t res [4];
      rotated_word_t e;
      raw = '{w, x, y, z};
      flag = 1'b0;
      for (int i = 0; i < 4; i++) begin
        qn[i] = raw[i][qsr_pkg::COMP_WIDTH-1];
        qm[i] = qn[i] ? 64'(comp_word_t'(-raw[i])) : 64'(raw[i]);
        if (qn[i] && raw[i] == {1'b1, {(qsr_pkg::COMP_WIDTH-1){1'b0}}})
          qm[i] = 64'(1) << (qsr_pkg::COMP_WIDTH - 1);
      end
      if (norm_en) unit_scale();
      if (start) take_reference();
      for (int c = 0; c < 4; c++) begin
        pos = '0;
        neg = '0;
        for (int t = 0; t < 4; t++) begin
          p = big_t'(inv_mag[t]) * big_t'(qm[c ^ t]);
          if ((inv_neg[t] != qn[c ^ t]) != TERM_FLIP[c][t]) neg = neg + p;
          else pos = pos + p;
        end
        if (pos >= neg) begin
          m = pos - neg;
          sn = 1'b0;
        end else begin
          m = neg - pos;
          sn = 1'b1;
        end
        m = (m + (big_t'(1) << (qsr_pkg::FRAC_BITS - 1))) >> qsr_pkg::FRAC_BITS;
        clip(sn, m, flag, on, om);
        res[c] = on ? comp_word_t'(-om) : comp_word_t'(om);
      end
      e.w = res[0];
      e.x = res[1];
      e.y = res[2];
      e.z = res[3];
      e.sat = flag;
      expected.push_back(e);
    endfunction

    function string check_result(rotated_word_t got);
      rotated_word_t e;
      string s;
      if (expected.size() == 0) return "result word with nothing expected";
      e = expected.pop_front();
      s = "";
      if (got.w !== e.w) s = {s, $sformatf(" w %h/%h", got.w, e.w)};
      if (got.x !== e.x) s = {s, $sformatf(" x %h/%h", got.x, e.x)};
      if (got.y !== e.y) s = {s, $sformatf(" y %h/%h", got.y, e.y)};
      if (got.z !== e.z) s = {s, $sformatf(" z %h/%h", got.z, e.z)};
      if (got.sat !== e.sat) s = {s, $sformatf(" sat %b/%b", got.sat, e.sat)};
      return s;
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write, cfg_data;
  logic in_valid, in_ready;
  comp_word_t in_w, in_x, in_y, in_z;
  logic series_start;
  logic out_valid, out_ready;
  comp_word_t out_w, out_x, out_y, out_z;
  logic saturated;

  reorient_scoreboard sb;
  int errors;
  int burst_left;
  int stall_mode;

  quaternion_series_reorient u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_w(in_w), .in_x(in_x), .in_y(in_y), .in_z(in_z), .series_start(series_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t:%s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    rotated_word_t got;
    string msg;
    if (!rst && out_valid && out_ready) begin
      got.w = out_w;
      got.x = out_x;
      got.y = out_y;
      got.z = out_z;
      got.sat = saturated;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  // receiver: switches between stall patterns every so often
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_word(comp_word_t w, comp_word_t x, comp_word_t y, comp_word_t z,
                           logic start);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_w <= w;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    series_start <= start;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w, x, y, z, start);
  endtask

  task automatic go_idle();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_norm(bit v);
    go_idle();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.norm_en = v;
  endtask

  function automatic comp_word_t rand_comp();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return '0;
           3: return 32'h0000_0001;
           default: return 32'hffff_ffff;
         endcase
      1, 2, 3, 4: return $urandom;
      default: return comp_word_t'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
    endcase
  endfunction

  task automatic directed_words();
    send_word(32'h1000_0000, 0, 0, 0, 1'b0);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_word(0, 0, 0, 0, 1'b1);
    send_word(32'h1000_0000, 32'h1000_0000, 0, 0, 1'b0);
    send_word(32'h1000_0000, 0, 0, 0, 1'b1);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_word(0, 0, 0, 0, 1'b0);
    send_word(32'h0000_0001, 32'hffff_ffff, 0, 0, 1'b1);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_word(32'h0b50_4f33, 32'hf4af_b0cd, 32'h0b50_4f33, 32'h0000_0000, 1'b1);
    send_word(32'h0000_0000, 32'h1000_0000, 32'hf000_0000, 32'h0800_0000, 1'b0);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b1);
  endtask

  task automatic random_words(int n);
    comp_word_t w, x, y, z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        w = '0; x = '0; y = '0; z = '0;
      end else begin
        w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
      end
      send_word(w, x, y, z, $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin
    int guard;
    sb = new();
    errors = 0;
    burst_left = 0;
    stall_mode = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_w = '0; in_x = '0; in_y = '0; in_z = '0;
    series_start = 1'b0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_words();
    write_norm(1'b0);
    directed_words();
    write_norm(1'b1);
    random_words(500);
    write_norm(1'b0);
    random_words(500);
    write_norm(1'b1);
    random_words(500);
    write_norm(1'b0);
    random_words(500);

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
    if (errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qsr_pkg.sv
rtl/qsr_mul.sv
rtl/qsr_divsqrt.sv
rtl/quaternion_series_reorient.sv
rtl/qsr_checker.sv
test/tb_top.sv
